@@ rtl/core/gsp_pkg.sv @@
package gsp_pkg;

	localparam int TERMS  = 6;
	localparam int COEF_W = 32;
	localparam int LEN_W  = 16;
	localparam int SUM_W  = 66;

	localparam int TERM_CONST = 0;
	localparam int TERM_L     = 1;
	localparam int TERM_R     = 2;
	localparam int TERM_LL    = 3;
	localparam int TERM_LR    = 4;
	localparam int TERM_RR    = 5;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	typedef logic [TERMS-1:0][COEF_W-1:0] gsp_coefs_t;

	typedef struct packed {
		logic [1:0] row;
		logic [3:0] col;
		logic       last;
	} gsp_tag_t;

endpackage

@@ rtl/core/gsp_coef_store.sv @@
module gsp_coef_store import gsp_pkg::*; #(
	parameter int ENTRIES = 48
) (
	input  logic                                            clk,
	input  logic                                            we,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_entry,
	input  logic [2:0]                                      wr_term,
	input  logic [COEF_W-1:0]                               wr_data,
	input  logic                                            re,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_entry,
	output gsp_coefs_t                                      rd_coefs
);

	for (genvar t = 0; t < TERMS; t++) begin : g_bank
		logic [COEF_W-1:0] mem [ENTRIES];
		logic [COEF_W-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (we && wr_term == 3'(t)) begin
				mem[wr_entry] <= wr_data;
			end
			if (re) begin
				rd_q <= mem[rd_entry];
			end
		end

		assign rd_coefs[t] = rd_q;
	end

endmodule

@@ rtl/core/gsp_datapath.sv @@
module gsp_datapath import gsp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      issue,
	input  gsp_tag_t                  tag_in,
	input  logic [LEN_W-1:0]          len_l,
	input  logic [LEN_W-1:0]          len_r,
	input  gsp_coefs_t                coefs_s1,
	output logic                      valid_s4,
	output gsp_tag_t                  tag_s4,
	output logic signed [COEF_W-1:0]  gain_s4
);

	logic                      v_s1, v_s2, v_s3;
	gsp_tag_t                  tag_s1, tag_s2, tag_s3;
	logic [LEN_W-1:0]          l_s1, r_s1;
	logic [2*LEN_W-1:0]        ll_s1, lr_s1, rr_s1;

	logic signed [COEF_W-1:0]  c0_s2;
	logic signed [48:0]        p1_s2, p2_s2;
	logic signed [63:0]        p3_s2, p4_s2, p5_s2;

	logic signed [SUM_W-1:0]   a_s3, b_s3;

	logic signed [SUM_W:0]     total;
	logic signed [34:0]        hi;
	logic signed [COEF_W-1:0]  sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			v_s1     <= issue;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			valid_s4 <= v_s3;
		end
	end

	// stage 1: squares and cross product of the lengths
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_in;
			l_s1   <= len_l;
			r_s1   <= len_r;
			ll_s1  <= len_l * len_l;
			lr_s1  <= len_l * len_r;
			rr_s1  <= len_r * len_r;
		end
	end

	// stage 2: coefficient products
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag_s1;
			c0_s2  <= $signed(coefs_s1[TERM_CONST]);
			p1_s2  <= 49'($signed(coefs_s1[TERM_L])) * 49'($signed({1'b0, l_s1}));
			p2_s2  <= 49'($signed(coefs_s1[TERM_R])) * 49'($signed({1'b0, r_s1}));
			p3_s2  <= 64'($signed(coefs_s1[TERM_LL])) * 64'($signed({1'b0, ll_s1}));
			p4_s2  <= 64'($signed(coefs_s1[TERM_LR])) * 64'($signed({1'b0, lr_s1}));
			p5_s2  <= 64'($signed(coefs_s1[TERM_RR])) * 64'($signed({1'b0, rr_s1}));
		end
	end

	// stage 3: partial sums, all aligned to 32 bits below the coefficient lsb
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s3 <= tag_s2;
			a_s3   <= (SUM_W'(c0_s2) <<< 32) + (SUM_W'(p1_s2) <<< 16)
				+ (SUM_W'(p2_s2) <<< 16);
			b_s3   <= SUM_W'(p3_s2) + SUM_W'(p4_s2) + SUM_W'(p5_s2)
				+ SUM_W'(64'sh8000_0000);
		end
	end

	// stage 4: round half up, saturate
	always_comb begin
		total = (SUM_W+1)'(a_s3) + (SUM_W+1)'(b_s3);
		hi    = total[SUM_W:32];
		if (hi[34:31] == 4'b0000 || hi[34:31] == 4'b1111) begin
			sat = hi[COEF_W-1:0];
		end else if (hi[34]) begin
			sat = {1'b1, {(COEF_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(COEF_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s4  <= tag_s3;
			gain_s4 <= sat;
		end
	end

endmodule

@@ rtl/core/gain_schedule_poly_eval.sv @@
// An accepted evaluate item sets busy_q; its first gain then passes stages s1 to s4.
// Throughput: one gain per cycle unless out_ready stalls the output; an evaluate item
//   holds the input while the entry counter walks all GAIN_ROWS*GAIN_COLS (48 by default)
//   coefficient bank entries; a write item never holds the input and yields no result.
// Output back-pressure freezes all four pipeline stages.
// Reset clears control state only; the coefficient table is undefined until written.
module gain_schedule_poly_eval import gsp_pkg::*; #(
	parameter int GAIN_ROWS = 4,
	parameter int GAIN_COLS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      command,
	input  logic [5:0]                entry_index,
	input  logic [2:0]                term_index,
	input  logic signed [31:0]        coef_value,
	input  logic [15:0]               left_length,
	input  logic [15:0]               right_length,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                gain_row,
	output logic [3:0]                gain_col,
	output logic signed [31:0]        gain_value,
	output logic                      last
);

	localparam int ENTRIES = GAIN_ROWS * GAIN_COLS;
	localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic              busy_q;
	logic [EW-1:0]     cnt_q;
	logic [1:0]        row_q;
	logic [3:0]        col_q;
	logic [LEN_W-1:0]  l_q, r_q;

	logic              accept, adv, issue, we, cnt_last;
	gsp_tag_t          tag_in;
	gsp_coefs_t        coefs_s1;
	gsp_tag_t          tag_s4;
	logic              valid_s4;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign adv      = !valid_s4 || out_ready;
	assign issue    = busy_q && adv;
	assign cnt_last = (cnt_q == EW'(ENTRIES - 1));
	assign we       = accept && command == CMD_WRITE
		&& {1'b0, entry_index} < 7'(ENTRIES) && term_index < 3'(TERMS);

	assign tag_in.row  = row_q;
	assign tag_in.col  = col_q;
	assign tag_in.last = cnt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (accept && command == CMD_EVAL) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (issue) begin
			if (cnt_last) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
			if (col_q == 4'(GAIN_COLS - 1)) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && command == CMD_EVAL) begin
			l_q <= left_length;
			r_q <= right_length;
		end
	end

	gsp_coef_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk      (clk),
		.we       (we),
		.wr_entry (entry_index[EW-1:0]),
		.wr_term  (term_index),
		.wr_data  (coef_value),
		.re       (issue),
		.rd_entry (cnt_q),
		.rd_coefs (coefs_s1)
	);

	gsp_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.issue    (issue),
		.tag_in   (tag_in),
		.len_l    (l_q),
		.len_r    (r_q),
		.coefs_s1 (coefs_s1),
		.valid_s4 (valid_s4),
		.tag_s4   (tag_s4),
		.gain_s4  (gain_value)
	);

	assign out_valid = valid_s4;
	assign gain_row  = tag_s4.row;
	assign gain_col  = tag_s4.col;
	assign last      = tag_s4.last;

endmodule
